// ----- rtl/core/mf7_pkg.sv -----
// Package for the 7x7 RGB median filter: sizes, register indexes and beat types.
// Used by mf7_lines, mf7_lane, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package mf7_pkg;
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int WINDOW     = 7;
    localparam int HALF       = WINDOW / 2;
    localparam int TAPS       = WINDOW * WINDOW;
    localparam int RANK       = TAPS / 2;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int CFG_W      = 10;
    localparam int IDX_W      = 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + HALF + 1);
    localparam int RING_W     = $clog2(WINDOW);
    localparam int RANK_W     = $clog2(TAPS + 1);
    localparam int TAIL_W     = $clog2(HALF + 1);
    localparam int CMP_W      = ((COL_W > CFG_W) ? COL_W : CFG_W) + 2;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            flush;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] red_median;
        logic [CH_W-1:0] green_median;
        logic [CH_W-1:0] blue_median;
        logic            end_of_row;
        logic            end_of_frame;
    } t_pix_out;

    typedef logic [WINDOW-1:0][PIX_W-1:0] t_column;
    typedef logic [TAPS-1:0][CH_W-1:0]    t_chan_win;

    typedef struct packed {
        logic              wr;
        logic [COL_W-1:0]  col;
        logic [RING_W-1:0] ring;
        logic [ROW_W-1:0]  row;
        logic [PIX_W-1:0]  pix;
    } t_line_ctl;

    typedef struct packed {
        logic valid;
        logic eor;
        logic eof;
    } t_tag;
endpackage
`default_nettype wire

// ----- rtl/core/mf7_ram.sv -----
// Generic single-port-write, registered-read RAM.
// Self-contained; used by mf7_lines for the line stores.
`timescale 1ns / 1ps
`default_nettype none
module mf7_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/mf7_lines.sv -----
// Line stores of the median filter: one RAM per ring row and the vertical column assembly.
// Depends on mf7_pkg and mf7_ram.
`timescale 1ns / 1ps
`default_nettype none
module mf7_lines (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire mf7_pkg::t_line_ctl       i_ctl,
    input  wire logic [mf7_pkg::ROW_W-1:0] i_height,
    output mf7_pkg::t_column              o_column
);
    import mf7_pkg::*;

    logic [PIX_W-1:0]  w_q [WINDOW];
    logic [PIX_W-1:0]  r_pix;
    logic [RING_W-1:0] r_ring;
    logic [ROW_W-1:0]  r_row;

    for (genvar g = 0; g < WINDOW; g++) begin : g_row
        mf7_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_ctl.wr && (i_ctl.ring == RING_W'(g))),
            .i_waddr (i_ctl.col),
            .i_wdata (i_ctl.pix),
            .i_re    (i_en),
            .i_raddr (i_ctl.col),
            .o_rdata (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix  <= i_ctl.pix;
            r_ring <= i_ctl.ring;
            r_row  <= i_ctl.row;
        end
    end

    always_comb begin
        logic [RING_W:0] idx;
        logic [ROW_W:0]  row_k;
        o_column = '0;
        for (int k = 0; k < WINDOW; k++) begin
            idx = (RING_W+1)'(r_ring) + (RING_W+1)'(k + 1);
            if (idx >= (RING_W+1)'(WINDOW)) begin
                idx = idx - (RING_W+1)'(WINDOW);
            end
            row_k = (ROW_W+1)'(r_row) + (ROW_W+1)'(k);
            if ((row_k >= (ROW_W+1)'(WINDOW - 1)) &&
                (row_k < (ROW_W+1)'(i_height) + (ROW_W+1)'(WINDOW - 1))) begin
                if (k == WINDOW - 1) begin
                    o_column[k] = r_pix;
                end else begin
                    o_column[k] = w_q[idx[RING_W-1:0]];
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/mf7_lane.sv -----
// One channel lane: pipelined bitwise selection of the middle value of the window.
// Depends on mf7_pkg; one stage per sample bit, most significant first.
`timescale 1ns / 1ps
`default_nettype none
module mf7_lane (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire mf7_pkg::t_chan_win      i_vals,
    output logic [mf7_pkg::CH_W-1:0]     o_median
);
    import mf7_pkg::*;

    t_chan_win         r_vals [CH_W];
    logic [TAPS-1:0]   r_mask [CH_W];
    logic [RANK_W-1:0] r_k    [CH_W];
    logic [CH_W-1:0]   r_res  [CH_W];

    for (genvar s = 0; s < CH_W; s++) begin : g_stage
        t_chan_win         p_vals;
        logic [TAPS-1:0]   p_mask;
        logic [RANK_W-1:0] p_k;
        logic [CH_W-1:0]   p_res;
        logic [TAPS-1:0]   n_mask;
        logic [RANK_W-1:0] n_k;
        logic [CH_W-1:0]   n_res;

        if (s == 0) begin : g_first
            assign p_vals = i_vals;
            assign p_mask = '1;
            assign p_k    = RANK_W'(RANK);
            assign p_res  = '0;
        end else begin : g_next
            assign p_vals = r_vals[s-1];
            assign p_mask = r_mask[s-1];
            assign p_k    = r_k[s-1];
            assign p_res  = r_res[s-1];
        end

        always_comb begin
            logic [RANK_W-1:0] cnt0;
            logic              bitv;
            cnt0 = '0;
            for (int i = 0; i < TAPS; i++) begin
                cnt0 = cnt0 + RANK_W'(p_mask[i] && !p_vals[i][CH_W-1-s]);
            end
            bitv = (p_k >= cnt0);
            for (int i = 0; i < TAPS; i++) begin
                n_mask[i] = p_mask[i] && (p_vals[i][CH_W-1-s] == bitv);
            end
            n_k = bitv ? (p_k - cnt0) : p_k;
            n_res = p_res;
            n_res[CH_W-1-s] = bitv;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vals[s] <= p_vals;
                r_mask[s] <= n_mask;
                r_k[s]    <= n_k;
                r_res[s]  <= n_res;
            end
        end
    end

    assign o_median = r_res[CH_W-1];
endmodule
`default_nettype wire

// ----- rtl/core/median_filter_7x7_rgb.sv -----
// Top level of the 7x7 RGB median filter: counters, window, border tail and output register.
// Depends on mf7_pkg, mf7_lines and mf7_lane.
//
// Pixels enter in raster order on the input channel (i_valid, o_stall, i_data), one beat per
// pixel. After the image the host sends three rows of beats with flush set. Each result beat
// (o_valid, i_stall, o_data) carries the three channel medians over the 7x7 window centred on
// one output pixel; samples outside the image count as zero.
// Throughput is one input beat per cycle while o_stall is low. The output for (y, x) is
// produced by input (y+3, x+3); the last input of a row also yields the three right-border
// results, which are issued from a saved window while no main result is due, and the first
// columns of the next row give none. A result beat passes the line-store read, the window
// and lane input register, the eight bit stages of each channel lane and the output
// register before it is presented on o_valid.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) set width and height, clamped to the
// supported range, and restart the frame; the host must make them while the block is idle,
// a rule left to the host. Reset sets width and height to 512 and empties the pipeline; no
// line-store clearing is needed. When the receiver stalls, the pipeline keeps moving until its
// last stage holds a result behind a full output register, and only then is the input stalled.
`timescale 1ns / 1ps
`default_nettype none
module median_filter_7x7_rgb (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [mf7_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [mf7_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire mf7_pkg::t_pix_in          i_data,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output mf7_pkg::t_pix_out              o_data
);
    import mf7_pkg::*;

    typedef t_column [WINDOW-1:0] t_win;

    logic [CFG_W-1:0]  r_width;
    logic [ROW_W-1:0]  r_height;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [RING_W-1:0] r_ring;
    logic              r_a_valid;
    logic [COL_W-1:0]  r_a_col;
    logic [ROW_W-1:0]  r_a_row;
    logic              r_a_last;
    t_win              r_win;
    t_win              n_win;
    t_win              r_tail;
    t_win              w_tail_sh;
    logic [TAIL_W-1:0] r_tail_cnt;
    logic              r_tail_eof;
    t_win              r_lin;
    t_tag              r_tag [CH_W+1];
    t_tag              n_tag;
    logic              r_o_valid;
    t_pix_out          r_o_data;

    logic              w_adv;
    logic              w_accept;
    logic              w_last;
    logic              w_main_emit;
    logic              w_tail_load;
    t_line_ctl         w_ctl;
    t_column           w_column;
    t_chan_win         w_chan [3];
    logic [CH_W-1:0]   w_med [3];

    assign w_adv    = !r_tag[CH_W].valid || !r_o_valid || !i_stall;
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;
    assign w_last   = (CMP_W'(r_col) == CMP_W'(r_width) - CMP_W'(1));

    always_comb begin
        w_ctl.wr   = w_accept;
        w_ctl.col  = r_col;
        w_ctl.ring = r_ring;
        w_ctl.row  = r_row;
        w_ctl.pix  = '0;
        if (!i_data.flush && (r_row < r_height)) begin
            w_ctl.pix = {i_data.red, i_data.green, i_data.blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(MAX_WIDTH);
            r_height <= ROW_W'(MAX_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
            r_ring   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WIDTH) begin
                if (CMP_W'(i_cfg_data) < CMP_W'(WINDOW)) begin
                    r_width <= CFG_W'(WINDOW);
                end else if (CMP_W'(i_cfg_data) > CMP_W'(MAX_WIDTH)) begin
                    r_width <= CFG_W'(MAX_WIDTH);
                end else begin
                    r_width <= i_cfg_data;
                end
            end else begin
                if (i_cfg_data == '0) begin
                    r_height <= ROW_W'(1);
                end else if (CMP_W'(i_cfg_data) > CMP_W'(MAX_HEIGHT)) begin
                    r_height <= ROW_W'(MAX_HEIGHT);
                end else begin
                    r_height <= ROW_W'(i_cfg_data);
                end
            end
            r_col  <= '0;
            r_row  <= '0;
            r_ring <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_col <= '0;
                if ((ROW_W+1)'(r_row) + (ROW_W+1)'(1) >=
                    (ROW_W+1)'(r_height) + (ROW_W+1)'(HALF)) begin
                    r_row  <= '0;
                    r_ring <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_ring <= (r_ring == RING_W'(WINDOW - 1)) ? '0 : r_ring + RING_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    mf7_lines u_lines (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_ctl    (w_ctl),
        .i_height (r_height),
        .o_column (w_column)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_col  <= r_col;
            r_a_row  <= r_row;
            r_a_last <= w_last;
        end
    end

    assign w_main_emit = r_a_valid && (r_a_row >= ROW_W'(HALF)) && (r_a_col >= COL_W'(HALF));
    assign w_tail_load = r_a_valid && r_a_last && (r_a_row >= ROW_W'(HALF));

    always_comb begin
        n_win = r_win;
        if (r_a_valid) begin
            if (r_a_col == '0) begin
                n_win = '0;
            end else begin
                for (int j = 0; j < WINDOW - 1; j++) begin
                    n_win[j] = r_win[j+1];
                end
            end
            n_win[WINDOW-1] = w_column;
        end
    end

    always_comb begin
        w_tail_sh = '0;
        for (int t = 1; t <= HALF; t++) begin
            for (int j = 0; j + t < WINDOW; j++) begin
                if (r_tail_cnt == TAIL_W'(HALF + 1 - t)) begin
                    w_tail_sh[j] = r_tail[j+t];
                end
            end
        end
    end

    always_comb begin
        n_tag = '0;
        if (w_main_emit) begin
            n_tag.valid = 1'b1;
        end else if (r_tail_cnt != '0) begin
            n_tag.valid = 1'b1;
            n_tag.eor   = (r_tail_cnt == TAIL_W'(1));
            n_tag.eof   = (r_tail_cnt == TAIL_W'(1)) && r_tail_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_cnt <= '0;
            for (int s = 0; s <= CH_W; s++) begin
                r_tag[s] <= '0;
            end
        end else if (w_adv) begin
            if (w_tail_load) begin
                r_tail_cnt <= TAIL_W'(HALF);
            end else if (!w_main_emit && (r_tail_cnt != '0)) begin
                r_tail_cnt <= r_tail_cnt - TAIL_W'(1);
            end
            r_tag[0] <= n_tag;
            for (int s = 1; s <= CH_W; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_win <= n_win;
            if (w_main_emit) begin
                r_lin <= n_win;
            end else begin
                r_lin <= w_tail_sh;
            end
            if (w_tail_load) begin
                r_tail     <= n_win;
                r_tail_eof <= ((ROW_W+1)'(r_a_row) ==
                               (ROW_W+1)'(r_height) + (ROW_W+1)'(HALF - 1));
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int c = 0; c < WINDOW; c++) begin
                for (int r = 0; r < WINDOW; r++) begin
                    w_chan[ch][c*WINDOW+r] = r_lin[c][r][(2-ch)*CH_W +: CH_W];
                end
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        mf7_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_adv),
            .i_vals   (w_chan[g]),
            .o_median (w_med[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_tag[CH_W].valid && (!r_o_valid || !i_stall)) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tag[CH_W].valid && (!r_o_valid || !i_stall)) begin
            r_o_data.red_median   <= w_med[0];
            r_o_data.green_median <= w_med[1];
            r_o_data.blue_median  <= w_med[2];
            r_o_data.end_of_row   <= r_tag[CH_W].eor;
            r_o_data.end_of_frame <= r_tag[CH_W].eof;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    a_no_slot_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_main_emit |-> (r_tail_cnt == '0))
        else $error("main window issued while border tail still pending");

    a_tail_idle_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_load |-> (r_tail_cnt == '0))
        else $error("border tail reloaded before it was drained");

    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag[CH_W].valid && r_tag[CH_W].eof |-> r_tag[CH_W].eor)
        else $error("end of frame without end of row");
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for median_filter_7x7_rgb: random-paced pixel frames with flush rows.
// Holds its own line-store predictor in a small scoreboard class; depends on mf7_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
    import mf7_pkg::*;

    class median_board;
        logic [PIX_W-1:0] rows [WINDOW][MAX_WIDTH];
        int unsigned col_pos, row_pos, width_reg, height_reg;
        t_pix_out pending [$];
        int errors;

        function void restart();
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void set_reg(int idx, int unsigned val);
            if (idx == REG_WIDTH) width_reg = val & 10'h3ff;
            else height_reg = val & 10'h3ff;
            restart();
        endfunction

        function int unsigned eff_w();
            if (width_reg < WINDOW) return WINDOW;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg < 1) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function logic [PIX_W-1:0] fetch(int r, int c, int w, int h);
            if (r < 0 || c < 0 || r >= h || c >= w) return '0;
            return rows[r % WINDOW][c];
        endfunction

        function void add_median(int oy, int ox, int w, int h);
            logic [CH_W-1:0] vals [TAPS];
            logic [CH_W-1:0] sorted [$];
            logic [PIX_W-1:0] p;
            t_pix_out res;
            int k;
            for (int ch = 0; ch < 3; ch++) begin
                k = 0;
                for (int dy = -HALF; dy <= HALF; dy++)
                    for (int dx = -HALF; dx <= HALF; dx++) begin
                        p = fetch(oy + dy, ox + dx, w, h);
                        vals[k] = p[(2 - ch) * CH_W +: CH_W];
                        k++;
                    end
                sorted = {};
                foreach (vals[i]) sorted.push_back(vals[i]);
                sorted.sort();
                if (ch == 0) res.red_median = sorted[RANK];
                else if (ch == 1) res.green_median = sorted[RANK];
                else res.blue_median = sorted[RANK];
            end
            res.end_of_row = (ox == w - 1);
            res.end_of_frame = res.end_of_row && (oy == h - 1);
            pending.push_back(res);
        endfunction

        function void note_input(t_pix_in d);
            int unsigned w, h, c, r;
            w = eff_w();
            h = eff_h();
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = (row_pos >= h + HALF) ? 0 : row_pos;
            rows[r % WINDOW][c] = (!d.flush && r < h) ? {d.red, d.green, d.blue} : '0;
            if (r >= HALF) begin
                if (c >= HALF) add_median(r - HALF, c - HALF, w, h);
                if (c == w - 1)
                    for (int ox = c - HALF + 1; ox < w; ox++) add_median(r - HALF, ox, w, h);
            end
            if (c == w - 1) begin
                col_pos = 0;
                row_pos = (r + 1 >= h + HALF) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        task check_result(t_pix_out got);
            t_pix_out want;
            if (pending.size() == 0) begin
                report_fault("result beat with nothing expected", got, got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) report_fault("result beat mismatch", got, want);
        endtask

        task report_fault(string what, t_pix_out got, t_pix_out want);
            $display("ERROR %s: got %h want %h", what, got, want);
            errors++;
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [IDX_W-1:0] i_cfg_idx = REG_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 0;
    logic o_stall;
    t_pix_in i_data = '0;
    logic o_valid;
    logic i_stall = 0;
    t_pix_out o_data;

    median_board board;
    bit hold_off = 0;
    bit feeding_done = 0;
    int idle_cycles = 0;

    localparam int WATCHDOG = 20000;

    always #5 i_clk = ~i_clk;

    median_filter_7x7_rgb u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) board.note_input(i_data);
            if (o_valid && !i_stall) board.check_result(o_data);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Receiver stall pattern: runs, gaps and a long hold-off when requested.
    initial begin
        int mode;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1;
            end else begin
                mode = $urandom_range(0, 15);
                i_stall <= (mode < 4) ? 1'b1 : (mode == 15 ? ~i_stall : 1'b0);
            end
        end
    end

    task automatic send_pixel(t_pix_in d, bit paced);
        if (paced && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 6)) begin
                i_valid <= 0;
                @(negedge i_clk);
            end
        i_valid <= 1;
        i_data <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_line();
        i_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_reg(idx, val);
    endtask

    task automatic settle();
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // Sends one frame plus its flush rows; mode 0 random, 1 extremes, 2 flush noise.
    task automatic send_frame(int w, int h, int mode, bit paced);
        t_pix_in d;
        int used_w, used_h;
        used_w = (w < WINDOW) ? WINDOW : w;
        used_h = (h < 1) ? 1 : h;
        for (int r = 0; r < used_h + HALF; r++)
            for (int c = 0; c < used_w; c++) begin
                d.red = CH_W'($urandom);
                d.green = CH_W'($urandom);
                d.blue = CH_W'($urandom);
                if (mode == 1) begin
                    d.red = ((r + c) % 2) ? 8'hff : 8'h00;
                    d.green = 8'hff;
                    d.blue = (c % 3 == 0) ? 8'h00 : 8'hff;
                end
                d.flush = (r >= used_h);
                if (mode == 2 && $urandom_range(0, 9) == 0) d.flush = ~d.flush;
                send_pixel(d, paced);
            end
    endtask

    initial begin
        board = new();
        board.width_reg = 512;
        board.height_reg = 512;
        board.errors = 0;
        board.restart();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        send_frame(7, 1, 1, 0);
        settle();
        write_reg(REG_WIDTH, 9);
        write_reg(REG_HEIGHT, 2);
        send_frame(9, 2, 2, 1);
        settle();

        write_reg(REG_WIDTH, 8);
        write_reg(REG_HEIGHT, 6);
        fork
            send_frame(8, 6, 0, 0);
            begin
                hold_off = 1;
                repeat (60) @(negedge i_clk);
                hold_off = 0;
            end
        join
        settle();

        write_reg(REG_WIDTH, 20);
        write_reg(REG_HEIGHT, 5);
        send_frame(20, 5, 0, 1);
        settle();

        write_reg(REG_HEIGHT, 3);
        write_reg(REG_WIDTH, 7);
        send_frame(7, 3, 0, 1);
        send_frame(7, 3, 2, 1);
        settle();

        write_reg(REG_WIDTH, 10);
        write_reg(REG_HEIGHT, 1023);
        send_frame(10, 4, 0, 1);
        settle();
        pause_line();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/mf7_pkg.sv
rtl/core/mf7_ram.sv
rtl/core/mf7_lines.sv
rtl/core/mf7_lane.sv
rtl/core/median_filter_7x7_rgb.sv
tb/sv/tb.sv
